// ===== design/mgs_pkg.sv =====
// Shared types and constants of the masked grid gradient stencil.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package mgs_pkg;

  // Grid limits and field widths
  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_MAX = 4096;
  localparam int DIST_BITS  = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(HEIGHT_MAX);
  localparam int GW_W       = 11;
  localparam int GH_W       = 13;
  localparam int RES_W      = 16;
  localparam int SLOPE_W    = 24;

  // Arithmetic widths: difference of two distances, then times the resolution
  localparam int DIFF_W  = DIST_BITS + 1;
  localparam int PROD_W  = DIFF_W + RES_W + 1;
  localparam int SLOPE_MAX = 8388607;
  localparam int SLOPE_MIN = -8388608;
  localparam int SH_ONE    = 8;   // one-sided difference
  localparam int SH_HALF   = 9;   // central difference, halved

  // Row store: three rows of MAX_WIDTH cells
  localparam int STORE_ROWS  = 3;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = 2;

  // Job queue between front and back
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = JOB_PTR_W + 1;
  localparam int EMIT_N    = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RESOLUTION = 2'd2;
  localparam logic [GW_W-1:0]  GW_RESET  = 11'd1024;
  localparam logic [GH_W-1:0]  GH_RESET  = 13'd1024;
  localparam logic [RES_W-1:0] RES_RESET = 16'd2560;

  typedef logic signed [DIST_BITS-1:0] dist_t;
  typedef logic signed [DIFF_W-1:0]    diff_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SLOPE_W-1:0]   slope_t;

  // One stored cell
  typedef struct packed {
    logic  ok;
    dist_t dval;
  } cell_t;

  // Column of three cells indexed by row (0: r-2, 1: r-1, 2: r),
  // window of three columns indexed by column (0: c-2, 1: c-1, 2: c)
  typedef cell_t [2:0] col_t;
  typedef col_t  [2:0] win_t;

  // Frame geometry as used by the front
  typedef struct packed {
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic             restart;
  } geom_t;

  // Work for the back: neighbourhood, position of the newest cell, results due
  // mask bit 0: (c-1,r-1), 1: (c,r-1), 2: (c-1,r), 3: (c,r)
  typedef struct packed {
    win_t              win;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [EMIT_N-1:0] mask;
  } job_t;

  // One finished result
  typedef struct packed {
    logic [COL_W-1:0] cell_x;
    logic [ROW_W-1:0] cell_y;
    slope_t           slope_x;
    slope_t           slope_y;
    logic             gradient_valid;
    logic             last_of_run;
  } result_t;

endpackage

`default_nettype wire

// ===== design/masked_grid_gradient_stencil.sv =====
// Top level of the masked grid gradient stencil: configuration registers,
// input credit check, front, job queue and back. Uses mgs_pkg and all mgs_ modules.
//
//  channel   handshake                 payload
//  ------    ------------------------  ------------------------------------------
//  cells     push / full               distance_i, distance_valid_i
//  results   empty / pop               cell_x_o, cell_y_o, slope_x_o, slope_y_o,
//                                      gradient_valid_o, last_of_run_o
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One cell per clock while full is low; a cell causes up to four results (last
// column, last row), and the back end puts out one result per clock unless the
// output word is held. A result passes the front register, the job queue and
// the back stages. full rises when the four-entry job queue is full, or has one
// entry left that the cell still in the front may take. rst_ni is asynchronous;
// the row store needs no clearing after reset.
`default_nettype none

module masked_grid_gradient_stencil (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // cell input
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [mgs_pkg::DIST_BITS-1:0]  distance_i,
  input  wire logic                                  distance_valid_i,
  // result output
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic [mgs_pkg::COL_W-1:0]                  cell_x_o,
  output logic [mgs_pkg::ROW_W-1:0]                  cell_y_o,
  output logic signed [mgs_pkg::SLOPE_W-1:0]         slope_x_o,
  output logic signed [mgs_pkg::SLOPE_W-1:0]         slope_y_o,
  output logic                                       gradient_valid_o,
  output logic                                       last_of_run_o,
  // configuration writes
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [mgs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [mgs_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  logic [mgs_pkg::GW_W-1:0]      grid_width_q;
  logic [mgs_pkg::GH_W-1:0]      grid_height_q;
  logic [mgs_pkg::RES_W-1:0]     inv_res_q;
  logic                          cfg_we, accept, busy;
  mgs_pkg::geom_t                geom;
  mgs_pkg::job_t                 push_job, head_job;
  logic                          job_push, job_pop, job_valid;
  logic [mgs_pkg::JOB_CNT_W-1:0] job_count;
  mgs_pkg::result_t              res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= mgs_pkg::GW_RESET;
      grid_height_q <= mgs_pkg::GH_RESET;
      inv_res_q     <= mgs_pkg::RES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        mgs_pkg::CFG_GRID_WIDTH:     grid_width_q  <= cfg_data_i[mgs_pkg::GW_W-1:0];
        mgs_pkg::CFG_GRID_HEIGHT:    grid_height_q <= cfg_data_i[mgs_pkg::GH_W-1:0];
        mgs_pkg::CFG_INV_RESOLUTION: inv_res_q     <= cfg_data_i[mgs_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry as last column / last row; size writes restart the frame
  always_comb begin
    if (grid_width_q == '0) begin
      geom.col_last = '0;
    end else if (grid_width_q > mgs_pkg::GW_W'(mgs_pkg::MAX_WIDTH)) begin
      geom.col_last = mgs_pkg::COL_W'(mgs_pkg::MAX_WIDTH - 1);
    end else begin
      geom.col_last = mgs_pkg::COL_W'(grid_width_q - mgs_pkg::GW_W'(1));
    end
    if (grid_height_q == '0) begin
      geom.row_last = '0;
    end else if (grid_height_q > mgs_pkg::GH_W'(mgs_pkg::HEIGHT_MAX)) begin
      geom.row_last = mgs_pkg::ROW_W'(mgs_pkg::HEIGHT_MAX - 1);
    end else begin
      geom.row_last = mgs_pkg::ROW_W'(grid_height_q - mgs_pkg::GH_W'(1));
    end
    geom.restart = cfg_we && ((cfg_index_i == mgs_pkg::CFG_GRID_WIDTH) ||
                              (cfg_index_i == mgs_pkg::CFG_GRID_HEIGHT));
  end

  // Credit: keep a queue entry for the cell still in the front
  assign full = (job_count == mgs_pkg::JOB_CNT_W'(mgs_pkg::JOB_DEPTH)) ||
                (busy && (job_count == mgs_pkg::JOB_CNT_W'(mgs_pkg::JOB_DEPTH - 1)));
  assign accept = push && !full;

  mgs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .geom_i           (geom),
    .accept_i         (accept),
    .distance_i       (distance_i),
    .distance_valid_i (distance_valid_i),
    .job_o            (push_job),
    .job_push_o       (job_push),
    .busy_o           (busy)
  );

  mgs_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (push_job),
    .pop_i   (job_pop),
    .head_o  (head_job),
    .valid_o (job_valid),
    .count_o (job_count)
  );

  mgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .inv_res_i   (inv_res_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign cell_x_o         = res.cell_x;
  assign cell_y_o         = res.cell_y;
  assign slope_x_o        = res.slope_x;
  assign slope_y_o        = res.slope_y;
  assign gradient_valid_o = res.gradient_valid;
  assign last_of_run_o    = res.last_of_run;

endmodule

`default_nettype wire

// ===== design/mgs_front.sv =====
// Front of the stencil: raster counters, three-row store and 3x3 window.
// Uses mgs_pkg; pushes one job per cell that causes results.
`default_nettype none

module mgs_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mgs_pkg::geom_t                geom_i,
  input  wire logic                          accept_i,
  input  wire logic signed [mgs_pkg::DIST_BITS-1:0] distance_i,
  input  wire logic                          distance_valid_i,
  output mgs_pkg::job_t                      job_o,
  output logic                               job_push_o,
  output logic                               busy_o
);

  logic [mgs_pkg::COL_W-1:0]  c_q;
  logic [mgs_pkg::ROW_W-1:0]  r_q;
  logic [mgs_pkg::SLOT_W-1:0] slot_q, slot_m1, slot_m2, slot_nx;
  logic                       last_col, last_row;
  logic [mgs_pkg::EMIT_N-1:0] mask_d;
  mgs_pkg::cell_t             wcell;
  logic [mgs_pkg::STORE_AW-1:0] waddr, raddr1, raddr2;

  mgs_pkg::cell_t             row_store_q [mgs_pkg::STORE_DEPTH];
  mgs_pkg::cell_t             rd1_q, rd2_q, s1_cell_q;
  logic [mgs_pkg::COL_W-1:0]  s1_c_q;
  logic [mgs_pkg::ROW_W-1:0]  s1_r_q;
  logic [mgs_pkg::EMIT_N-1:0] s1_mask_q;
  logic                       s1_valid_q;
  mgs_pkg::col_t              col1_q, col2_q, cur;

  // Slot of rows r-1, r-2 and r+1 (rows rotate through three slots)
  always_comb begin
    case (slot_q)
      2'd0:    begin slot_m1 = 2'd2; slot_m2 = 2'd1; slot_nx = 2'd1; end
      2'd1:    begin slot_m1 = 2'd0; slot_m2 = 2'd2; slot_nx = 2'd2; end
      default: begin slot_m1 = 2'd1; slot_m2 = 2'd0; slot_nx = 2'd0; end
    endcase
  end

  // Store addresses: slot * MAX_WIDTH + column
  assign waddr  = mgs_pkg::STORE_AW'(slot_q) * mgs_pkg::STORE_AW'(mgs_pkg::MAX_WIDTH)
                + mgs_pkg::STORE_AW'(c_q);
  assign raddr1 = mgs_pkg::STORE_AW'(slot_m1) * mgs_pkg::STORE_AW'(mgs_pkg::MAX_WIDTH)
                + mgs_pkg::STORE_AW'(c_q);
  assign raddr2 = mgs_pkg::STORE_AW'(slot_m2) * mgs_pkg::STORE_AW'(mgs_pkg::MAX_WIDTH)
                + mgs_pkg::STORE_AW'(c_q);

  // Which results this cell causes
  assign last_col = (c_q == geom_i.col_last);
  assign last_row = (r_q == geom_i.row_last);
  always_comb begin
    mask_d[0] = (r_q != '0) && (c_q != '0);
    mask_d[1] = (r_q != '0) && last_col;
    mask_d[2] = last_row && (c_q != '0);
    mask_d[3] = last_row && last_col;
  end

  assign wcell.ok   = distance_valid_i;
  assign wcell.dval = distance_i;

  // Raster position of the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q    <= '0;
      r_q    <= '0;
      slot_q <= '0;
    end else if (geom_i.restart) begin
      c_q    <= '0;
      r_q    <= '0;
      slot_q <= '0;
    end else if (accept_i) begin
      if (last_col) begin
        c_q <= '0;
        if (last_row) begin
          r_q    <= '0;
          slot_q <= '0;
        end else begin
          r_q    <= r_q + mgs_pkg::ROW_W'(1);
          slot_q <= slot_nx;
        end
      end else begin
        c_q <= c_q + mgs_pkg::COL_W'(1);
      end
    end
  end

  // Row store: write the new cell, read the two rows above it
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      row_store_q[waddr] <= wcell;
      rd1_q              <= row_store_q[raddr1];
      rd2_q              <= row_store_q[raddr2];
      s1_cell_q          <= wcell;
      s1_c_q             <= c_q;
      s1_r_q             <= r_q;
      s1_mask_q          <= mask_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  // Newest column, then shift the window one column on
  always_comb begin
    cur[0] = rd2_q;
    cur[1] = rd1_q;
    cur[2] = s1_cell_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      col2_q <= col1_q;
      col1_q <= cur;
    end
  end

  always_comb begin
    job_o.win[0] = col2_q;
    job_o.win[1] = col1_q;
    job_o.win[2] = cur;
    job_o.col    = s1_c_q;
    job_o.row    = s1_r_q;
    job_o.mask   = s1_mask_q;
  end

  assign job_push_o = s1_valid_q && (s1_mask_q != '0);
  assign busy_o     = s1_valid_q;

endmodule

`default_nettype wire

// ===== design/mgs_job_fifo.sv =====
// Short job queue between the front and the back of the stencil.
// Uses mgs_pkg for the job word and the depth.
`default_nettype none

module mgs_job_fifo (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire mgs_pkg::job_t                job_i,
  input  wire logic                         pop_i,
  output mgs_pkg::job_t                     head_o,
  output logic                              valid_o,
  output logic [mgs_pkg::JOB_CNT_W-1:0]     count_o
);

  mgs_pkg::job_t                 slot_q [mgs_pkg::JOB_DEPTH];
  logic [mgs_pkg::JOB_PTR_W-1:0] wptr_q, rptr_q;
  logic [mgs_pkg::JOB_CNT_W-1:0] cnt_q;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + mgs_pkg::JOB_PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + mgs_pkg::JOB_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + mgs_pkg::JOB_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - mgs_pkg::JOB_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o  = slot_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// ===== design/mgs_back.sv =====
// Back of the stencil: expands each job into its results, forms the masked
// differences, scales them by the resolution and rounds and saturates.
// Uses mgs_pkg; three register stages, the last one is the output word.
`default_nettype none

module mgs_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mgs_pkg::job_t               job_i,
  input  wire logic                        job_valid_i,
  output logic                             job_pop_o,
  input  wire logic [mgs_pkg::RES_W-1:0]   inv_res_i,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output mgs_pkg::result_t                 res_o
);

  typedef struct packed {
    mgs_pkg::diff_t diff;
    logic           half;
    logic           zero;
  } axis_t;

  // Masked difference along one axis
  function automatic axis_t axis_f(input logic lo_ok, input mgs_pkg::dist_t lo,
                                   input mgs_pkg::dist_t mid, input logic hi_ok,
                                   input mgs_pkg::dist_t hi);
    axis_t a;
    a.diff = '0;
    a.half = 1'b0;
    a.zero = 1'b0;
    if (lo_ok && hi_ok) begin
      a.diff = mgs_pkg::DIFF_W'(hi) - mgs_pkg::DIFF_W'(lo);
      a.half = 1'b1;
    end else if (hi_ok) begin
      a.diff = mgs_pkg::DIFF_W'(hi) - mgs_pkg::DIFF_W'(mid);
    end else if (lo_ok) begin
      a.diff = mgs_pkg::DIFF_W'(mid) - mgs_pkg::DIFF_W'(lo);
    end else begin
      a.zero = 1'b1;
    end
    return a;
  endfunction

  // Round half up, shift, saturate to Q16.8
  function automatic mgs_pkg::slope_t round_sat(input mgs_pkg::prod_t p, input logic half);
    mgs_pkg::prod_t q, s, smax, smin;
    smax = mgs_pkg::PROD_W'(mgs_pkg::SLOPE_MAX);
    smin = mgs_pkg::PROD_W'(mgs_pkg::SLOPE_MIN);
    if (half) begin
      q = p + mgs_pkg::PROD_W'(1 << (mgs_pkg::SH_HALF - 1));
      s = q >>> mgs_pkg::SH_HALF;
    end else begin
      q = p + mgs_pkg::PROD_W'(1 << (mgs_pkg::SH_ONE - 1));
      s = q >>> mgs_pkg::SH_ONE;
    end
    if (s > smax) begin
      s = smax;
    end else if (s < smin) begin
      s = smin;
    end
    return s[mgs_pkg::SLOPE_W-1:0];
  endfunction

  logic                       en, issue, last;
  logic [mgs_pkg::EMIT_N-1:0] done_q, pending, sel_bit;
  logic [1:0]                 sel, cr, cc;
  mgs_pkg::cell_t             mid, left, right, down, up;
  logic                       left_ok, right_ok, down_ok, up_ok;
  axis_t                      ax, ay;

  logic                       v1_q, v2_q, v3_q;
  axis_t                      ax1_q, ay1_q;
  logic                       gv1_q, last1_q, gv2_q, last2_q;
  logic [mgs_pkg::COL_W-1:0]  cx1_q, cx2_q;
  logic [mgs_pkg::ROW_W-1:0]  cy1_q, cy2_q;
  mgs_pkg::prod_t             px2_q, py2_q;
  logic                       hx2_q, hy2_q, zx2_q, zy2_q;
  logic signed [mgs_pkg::RES_W:0] res_s;
  mgs_pkg::result_t           res_q;

  // Whole pipe moves unless the output word is held
  assign en    = !v3_q || pop_i;
  assign issue = en && job_valid_i;

  // Next result of the head job: lowest bit still due
  always_comb begin
    pending = job_i.mask & ~done_q;
    if (pending[0]) begin
      sel = 2'd0;
    end else if (pending[1]) begin
      sel = 2'd1;
    end else if (pending[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_bit = mgs_pkg::EMIT_N'(1) << sel;
    last    = ((pending & ~sel_bit) == '0);
  end

  assign job_pop_o = issue && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else if (issue) begin
      done_q <= last ? '0 : (done_q | sel_bit);
    end
  end

  // Neighbourhood of the selected centre; window is [column][row]
  always_comb begin
    cr    = sel[1] ? 2'd2 : 2'd1;
    cc    = sel[0] ? 2'd2 : 2'd1;
    mid   = job_i.win[cc][cr];
    left  = job_i.win[cc - 2'd1][cr];
    right = job_i.win[2'd2][cr];
    down  = job_i.win[cc][cr - 2'd1];
    up    = job_i.win[cc][2'd2];
    left_ok  = left.ok && (sel[0] ? (job_i.col != '0)
                                  : (job_i.col >= mgs_pkg::COL_W'(2)));
    right_ok = right.ok && !sel[0];
    down_ok  = down.ok && (sel[1] ? (job_i.row != '0)
                                  : (job_i.row >= mgs_pkg::ROW_W'(2)));
    up_ok    = up.ok && !sel[1];
    ax = axis_f(left_ok, left.dval, mid.dval, right_ok, right.dval);
    ay = axis_f(down_ok, down.dval, mid.dval, up_ok, up.dval);
    if (!mid.ok) begin
      ax.zero = 1'b1;
      ay.zero = 1'b1;
    end
  end

  assign res_s = $signed({1'b0, inv_res_i});

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= job_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads: differences, products, rounded result
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q   <= ax;
      ay1_q   <= ay;
      gv1_q   <= mid.ok;
      last1_q <= last;
      cx1_q   <= job_i.col - mgs_pkg::COL_W'(1) + mgs_pkg::COL_W'(sel[0]);
      cy1_q   <= job_i.row - mgs_pkg::ROW_W'(1) + mgs_pkg::ROW_W'(sel[1]);

      px2_q   <= mgs_pkg::PROD_W'(ax1_q.diff) * mgs_pkg::PROD_W'(res_s);
      py2_q   <= mgs_pkg::PROD_W'(ay1_q.diff) * mgs_pkg::PROD_W'(res_s);
      hx2_q   <= ax1_q.half;
      hy2_q   <= ay1_q.half;
      zx2_q   <= ax1_q.zero;
      zy2_q   <= ay1_q.zero;
      gv2_q   <= gv1_q;
      last2_q <= last1_q;
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;

      res_q.cell_x         <= cx2_q;
      res_q.cell_y         <= cy2_q;
      res_q.slope_x        <= zx2_q ? '0 : round_sat(px2_q, hx2_q);
      res_q.slope_y        <= zy2_q ? '0 : round_sat(py2_q, hy2_q);
      res_q.gradient_valid <= gv2_q;
      res_q.last_of_run    <= last2_q;
    end
  end

  assign empty_o = !v3_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== bench/tb_masked_grid_gradient_stencil.sv =====
// Self-checking bench for masked_grid_gradient_stencil: raster cell stream in,
// predicted x/y gradients out, checked word by word in acceptance order.
// Depends on mgs_pkg and the design files; reads no files.
`timescale 1ns / 100ps

// Gradient predictor and store of expected result words
class gradient_scoreboard;
  logic [mgs_pkg::DIST_BITS:0] cell_rows [mgs_pkg::STORE_DEPTH];
  int unsigned                 width_reg;
  int unsigned                 height_reg;
  int unsigned                 res_reg;
  int unsigned                 next_col;
  int unsigned                 next_row;
  mgs_pkg::result_t            pending_gradients [$];
  int unsigned                 errors;
  int unsigned                 cells_taken;
  int unsigned                 gradients_checked;
  int unsigned                 corner_runs;
  int unsigned                 reg_writes;

  function void clear();
    foreach (cell_rows[i]) cell_rows[i] = '0;
    width_reg         = 32'(mgs_pkg::GW_RESET);
    height_reg        = 32'(mgs_pkg::GH_RESET);
    res_reg           = 32'(mgs_pkg::RES_RESET);
    next_col          = 0;
    next_row          = 0;
    pending_gradients.delete();
    errors            = 0;
    cells_taken       = 0;
    gradients_checked = 0;
    corner_runs       = 0;
    reg_writes        = 0;
  endfunction

  // Geometry writes restart the frame; the row store is kept
  function void write_reg(logic [mgs_pkg::CFG_IDX_W-1:0] idx,
                          logic [mgs_pkg::CFG_DATA_W-1:0] data);
    reg_writes++;
    case (idx)
      mgs_pkg::CFG_GRID_WIDTH: begin
        width_reg = 32'(data & 16'h07FF);
        next_col  = 0;
        next_row  = 0;
      end
      mgs_pkg::CFG_GRID_HEIGHT: begin
        height_reg = 32'(data & 16'h1FFF);
        next_col   = 0;
        next_row   = 0;
      end
      mgs_pkg::CFG_INV_RESOLUTION: res_reg = 32'(data);
      default: ;
    endcase
  endfunction

  function int unsigned grid_cols();
    if (width_reg < 1) return 1;
    if (width_reg > mgs_pkg::MAX_WIDTH) return mgs_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function int unsigned grid_rows();
    if (height_reg < 1) return 1;
    if (height_reg > mgs_pkg::HEIGHT_MAX) return mgs_pkg::HEIGHT_MAX;
    return height_reg;
  endfunction

  function int unsigned slot(int unsigned x, int unsigned y);
    return (y % 3) * mgs_pkg::MAX_WIDTH + (x % mgs_pkg::MAX_WIDTH);
  endfunction

  function bit is_finite(int unsigned x, int unsigned y);
    return cell_rows[slot(x, y)][mgs_pkg::DIST_BITS];
  endfunction

  function longint dist_at(int unsigned x, int unsigned y);
    return longint'($signed(cell_rows[slot(x, y)][mgs_pkg::DIST_BITS-1:0]));
  endfunction

  // difference times resolution, rounded half up by a floor shift, saturated
  function mgs_pkg::slope_t scaled_diff(longint diff, int unsigned sh);
    longint q;
    q = diff * longint'(res_reg) + (longint'(1) << (sh - 1));
    q = q >>> sh;
    if (q > mgs_pkg::SLOPE_MAX) q = mgs_pkg::SLOPE_MAX;
    if (q < mgs_pkg::SLOPE_MIN) q = mgs_pkg::SLOPE_MIN;
    return q[mgs_pkg::SLOPE_W-1:0];
  endfunction

  // central where both neighbours are finite, one-sided where one is
  function mgs_pkg::slope_t axis_gradient(bit lo_ok, longint lo, longint mid,
                                          bit hi_ok, longint hi);
    if (lo_ok && hi_ok) return scaled_diff(hi - lo, mgs_pkg::SH_HALF);
    if (hi_ok) return scaled_diff(hi - mid, mgs_pkg::SH_ONE);
    if (lo_ok) return scaled_diff(mid - lo, mgs_pkg::SH_ONE);
    return '0;
  endfunction

  function void predict_gradient(int unsigned x, int unsigned y,
                                 int unsigned w, int unsigned h);
    mgs_pkg::result_t g;
    bit               l;
    bit               r;
    bit               d;
    bit               u;
    longint           mid;
    g        = '0;
    g.cell_x = x[mgs_pkg::COL_W-1:0];
    g.cell_y = y[mgs_pkg::ROW_W-1:0];
    if (is_finite(x, y)) begin
      mid = dist_at(x, y);
      l   = (x > 0) && is_finite(x - 1, y);
      r   = (x + 1 < w) && is_finite(x + 1, y);
      d   = (y > 0) && is_finite(x, y - 1);
      u   = (y + 1 < h) && is_finite(x, y + 1);
      g.slope_x = axis_gradient(l, l ? dist_at(x - 1, y) : 0, mid,
                                r, r ? dist_at(x + 1, y) : 0);
      g.slope_y = axis_gradient(d, d ? dist_at(x, y - 1) : 0, mid,
                                u, u ? dist_at(x, y + 1) : 0);
      g.gradient_valid = 1'b1;
    end
    pending_gradients = {pending_gradients, g};
  endfunction

  // Store an accepted cell and queue the words it releases
  function void take_cell(logic signed [mgs_pkg::DIST_BITS-1:0] dval, logic ok);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned queued;
    w      = grid_cols();
    h      = grid_rows();
    c      = (next_col >= w) ? w - 1 : next_col;
    r      = (next_row >= h) ? h - 1 : next_row;
    queued = pending_gradients.size();
    cell_rows[slot(c, r)] = {ok, dval};
    if (r >= 1) begin
      if (c >= 1) predict_gradient(c - 1, r - 1, w, h);
      if (c == w - 1) predict_gradient(c, r - 1, w, h);
    end
    if (r == h - 1) begin
      if (c >= 1) predict_gradient(c - 1, r, w, h);
      if (c == w - 1) predict_gradient(c, r, w, h);
    end
    if (pending_gradients.size() > queued)
      pending_gradients[pending_gradients.size() - 1].last_of_run = 1'b1;
    if (pending_gradients.size() - queued == mgs_pkg::EMIT_N) corner_runs++;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
    cells_taken++;
  endfunction

  function void compare_field(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Check one popped word against the oldest expectation
  function void check_gradient(mgs_pkg::result_t got);
    mgs_pkg::result_t want;
    gradients_checked++;
    if (pending_gradients.size() == 0) begin
      errors++;
      $error("word for cell (%0d,%0d) with none expected", got.cell_x, got.cell_y);
      return;
    end
    want = pending_gradients.pop_front();
    compare_field("cell_x", 64'(want.cell_x), 64'(got.cell_x));
    compare_field("cell_y", 64'(want.cell_y), 64'(got.cell_y));
    compare_field("slope_x", 64'(want.slope_x), 64'(got.slope_x));
    compare_field("slope_y", 64'(want.slope_y), 64'(got.slope_y));
    compare_field("gradient_valid", 64'(want.gradient_valid), 64'(got.gradient_valid));
    compare_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
  endfunction
endclass

module tb_masked_grid_gradient_stencil;
  localparam logic [mgs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unused index
  localparam int HOLD_OFF    = 200;   // long output stall
  localparam int PIPE_SLACK  = 16;    // cycles for cells still in flight
  localparam int STALL_LIMIT = 3000;  // cycles without any word moving

  logic                                   clk_i;
  logic                                   rst_ni           = 1'b0;
  logic                                   push             = 1'b0;
  logic                                   full;
  logic signed [mgs_pkg::DIST_BITS-1:0]   distance_i       = '0;
  logic                                   distance_valid_i = 1'b0;
  logic                                   empty;
  logic                                   pop              = 1'b0;
  logic [mgs_pkg::COL_W-1:0]              cell_x_o;
  logic [mgs_pkg::ROW_W-1:0]              cell_y_o;
  logic signed [mgs_pkg::SLOPE_W-1:0]     slope_x_o;
  logic signed [mgs_pkg::SLOPE_W-1:0]     slope_y_o;
  logic                                   gradient_valid_o;
  logic                                   last_of_run_o;
  logic                                   cfg_valid_i      = 1'b0;
  logic                                   cfg_ready_o;
  logic [mgs_pkg::CFG_IDX_W-1:0]          cfg_index_i      = '0;
  logic [mgs_pkg::CFG_DATA_W-1:0]         cfg_data_i       = '0;

  gradient_scoreboard grads = new;
  mgs_pkg::result_t   popped_word;
  int unsigned        cell_gap_max  = 2;
  int unsigned        pop_gap_max   = 2;
  bit                 hold_off_req  = 1'b0;

  masked_grid_gradient_stencil u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .distance_i       (distance_i),
    .distance_valid_i (distance_valid_i),
    .empty            (empty),
    .pop              (pop),
    .cell_x_o         (cell_x_o),
    .cell_y_o         (cell_y_o),
    .slope_x_o        (slope_x_o),
    .slope_y_o        (slope_y_o),
    .gradient_valid_o (gradient_valid_o),
    .last_of_run_o    (last_of_run_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Monitor: register writes, accepted cells and popped words, in that order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) grads.write_reg(cfg_index_i, cfg_data_i);
      if (push && !full) grads.take_cell(distance_i, distance_valid_i);
      if (pop && !empty) begin
        popped_word.cell_x         = cell_x_o;
        popped_word.cell_y         = cell_y_o;
        popped_word.slope_x        = slope_x_o;
        popped_word.slope_y        = slope_y_o;
        popped_word.gradient_valid = gradient_valid_o;
        popped_word.last_of_run    = last_of_run_o;
        grads.check_gradient(popped_word);
      end
    end
  end

  // Watchdog: ends the run once nothing has moved for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result sink: random pop gaps, plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end
      gap = $urandom_range(0, pop_gap_max);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty && !hold_off_req);
    end
  end

  // Offer one cell after a random gap and wait until it is taken
  task automatic send_cell(input logic signed [mgs_pkg::DIST_BITS-1:0] dval,
                           input logic ok);
    int unsigned gap;
    gap = $urandom_range(0, cell_gap_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    distance_i       <= dval;
    distance_valid_i <= ok;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mgs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mgs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] cols, input logic [15:0] rows,
                           input bit with_res, input logic [15:0] res);
    write_reg(mgs_pkg::CFG_GRID_WIDTH, cols);
    write_reg(mgs_pkg::CFG_GRID_HEIGHT, rows);
    if (with_res) write_reg(mgs_pkg::CFG_INV_RESOLUTION, res);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, wait for every expected word, then let the pipe empty
  task automatic settle();
    push        <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (grads.pending_gradients.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] random_distance();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 17;
    endcase
  endfunction

  // One random geometry: whole frames mostly, sometimes a frame cut short
  task automatic random_phase(output int unsigned sent);
    logic [15:0] cols;
    logic [15:0] rows;
    logic [15:0] res;
    int unsigned frame;
    int unsigned pct;
    case ($urandom_range(0, 9))
      0:       cols = 16'd0;
      1:       cols = 16'($urandom_range(9, 40));
      default: cols = 16'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       rows = 16'd0;
      1:       rows = 16'($urandom_range(7, 12));
      default: rows = 16'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 5))
      0:       res = 16'hFFFF;
      1:       res = 16'd1;
      2:       res = 16'($urandom_range(1, 1024));
      default: res = 16'($urandom());
    endcase
    case ($urandom_range(0, 3))
      0:       pct = 50;
      1:       pct = 100;
      default: pct = 85;
    endcase
    frame = ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows);
    sent  = ($urandom_range(0, 6) == 0) ? $urandom_range(1, frame)
                                        : frame * $urandom_range(1, 2);
    if (sent > 36) sent = 36;
    settle();
    cell_gap_max = pick_gap_max();
    pop_gap_max  = pick_gap_max();
    configure(cols, rows, $urandom_range(0, 2) != 0, res);
    repeat (sent) send_cell(random_distance(), $urandom_range(1, 100) <= pct);
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned random_cells;
    int unsigned batch;
    grads.clear();
    random_cells = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: cells land in row 0 of a wide frame, nothing comes out
    send_cell(16'sh8000, 1'b1);
    send_cell(16'sh7FFF, 1'b1);
    send_cell(16'sh0000, 1'b0);

    // 3x3 at the largest resolution: saturation both ways, an invalid centre,
    // one-sided edges and four words from the corner cell; spare index ignored
    settle();
    write_reg(CFG_SPARE, 16'hFFFF);
    configure(16'd3, 16'd3, 1'b1, 16'hFFFF);
    send_cell(16'sh7FFF, 1'b1);
    send_cell(16'sh8000, 1'b1);
    send_cell(16'sh7FFF, 1'b1);
    send_cell(16'sh8000, 1'b1);
    send_cell(16'sh0000, 1'b0);
    send_cell(16'sh0001, 1'b1);
    send_cell(16'sh7FFF, 1'b1);
    send_cell(16'shFFFF, 1'b1);
    send_cell(16'sh8000, 1'b1);

    // single row: a finite centre with no finite neighbour on either axis
    settle();
    configure(16'd3, 16'd1, 1'b1, 16'd256);
    send_cell(16'sd100, 1'b0);
    send_cell(16'sd200, 1'b1);
    send_cell(16'sd300, 1'b0);

    // zero resolution flattens every slope
    settle();
    configure(16'd2, 16'd2, 1'b1, 16'd0);
    send_cell(16'sh7FFF, 1'b1);
    send_cell(16'sh8000, 1'b1);
    send_cell(16'sh8000, 1'b1);
    send_cell(16'sh7FFF, 1'b1);

    // zero width and height clamp to a single cell frame
    settle();
    configure(16'd0, 16'd0, 1'b1, 16'd1);
    send_cell(16'sh7FFF, 1'b1);
    send_cell(16'sh1234, 1'b0);
    send_cell(16'sh8000, 1'b1);

    // back-pressure: output held off while a 4x4 stream keeps coming
    settle();
    cell_gap_max = 0;
    configure(16'd4, 16'd4, 1'b1, 16'd2560);
    hold_off_req = 1'b1;
    repeat (32) send_cell(random_distance(), $urandom_range(0, 7) != 0);

    // random geometries and content
    while (random_cells < 72) begin
      random_phase(batch);
      random_cells += batch;
    end

    // width over range clamped to the maximum: the row does not wrap early
    settle();
    cell_gap_max = 0;
    pop_gap_max  = 0;
    configure(16'hFFFF, 16'd1, 1'b1, 16'd4660);
    repeat (24) send_cell(random_distance(), $urandom_range(0, 9) != 0);

    // height over range clamped to the maximum, start of a tall frame
    settle();
    cell_gap_max = 17;
    pop_gap_max  = 17;
    configure(16'd2, 16'hFFFF, 1'b0, 16'd0);
    repeat (16) send_cell(random_distance(), 1'b1);

    settle();
    $display("Run covered %0d cells, %0d words (%0d four-word cells), %0d register writes.",
             grads.cells_taken, grads.gradients_checked, grads.corner_runs,
             grads.reg_writes);
    if (grads.errors == 0 && grads.pending_gradients.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/mgs_pkg.sv
design/mgs_front.sv
design/mgs_job_fifo.sv
design/mgs_back.sv
design/masked_grid_gradient_stencil.sv
bench/tb_masked_grid_gradient_stencil.sv
